[design/mpd_pkg.sv]
`timescale 1ns / 1ps
package mpd_pkg;

   localparam logic [15:0] CP_REPLACE = 16'hFFFD;
   localparam logic [15:0] CP_SPACE   = 16'h0020;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] code_point;
      logic        last_of_run;
   } result_type;

   // up to two words per input byte, packed from slot0
   typedef struct packed {
      logic [1:0] num;
      result_type slot0;
      result_type slot1;
   } result_pair_type;

   // key is {symbol count, symbols}; symbol i sits in bit i, dash = 1
   function automatic logic [15:0] letter_lookup(input logic [3:0] count,
                                                 input logic [7:0] symbols);
      logic [15:0] cp;
      unique case ({count, symbols})
         {4'd2, 8'b10}:       cp = 16'h0041;
         {4'd4, 8'b0001}:     cp = 16'h0042;
         {4'd4, 8'b0101}:     cp = 16'h0043;
         {4'd3, 8'b001}:      cp = 16'h0044;
         {4'd1, 8'b0}:        cp = 16'h0045;
         {4'd4, 8'b0100}:     cp = 16'h0046;
         {4'd3, 8'b011}:      cp = 16'h0047;
         {4'd4, 8'b0000}:     cp = 16'h0048;
         {4'd2, 8'b00}:       cp = 16'h0049;
         {4'd4, 8'b1110}:     cp = 16'h004A;
         {4'd3, 8'b101}:      cp = 16'h004B;
         {4'd4, 8'b0010}:     cp = 16'h004C;
         {4'd2, 8'b11}:       cp = 16'h004D;
         {4'd2, 8'b01}:       cp = 16'h004E;
         {4'd3, 8'b111}:      cp = 16'h004F;
         {4'd4, 8'b0110}:     cp = 16'h0050;
         {4'd4, 8'b1011}:     cp = 16'h0051;
         {4'd3, 8'b010}:      cp = 16'h0052;
         {4'd3, 8'b000}:      cp = 16'h0053;
         {4'd1, 8'b1}:        cp = 16'h0054;
         {4'd3, 8'b100}:      cp = 16'h0055;
         {4'd4, 8'b1000}:     cp = 16'h0056;
         {4'd3, 8'b110}:      cp = 16'h0057;
         {4'd4, 8'b1001}:     cp = 16'h0058;
         {4'd4, 8'b1101}:     cp = 16'h0059;
         {4'd4, 8'b0011}:     cp = 16'h005A;
         {4'd5, 8'b11110}:    cp = 16'h0031;
         {4'd5, 8'b11100}:    cp = 16'h0032;
         {4'd5, 8'b11000}:    cp = 16'h0033;
         {4'd5, 8'b10000}:    cp = 16'h0034;
         {4'd5, 8'b00000}:    cp = 16'h0035;
         {4'd5, 8'b00001}:    cp = 16'h0036;
         {4'd5, 8'b00011}:    cp = 16'h0037;
         {4'd5, 8'b00111}:    cp = 16'h0038;
         {4'd5, 8'b01111}:    cp = 16'h0039;
         {4'd5, 8'b11111}:    cp = 16'h0030;
         {4'd5, 8'b01010}:    cp = 16'h002B;
         {4'd5, 8'b10001}:    cp = 16'h003D;
         {4'd5, 8'b01001}:    cp = 16'h002F;
         {4'd5, 8'b00010}:    cp = 16'h0026;
         {4'd6, 8'b001100}:   cp = 16'h003F;
         {4'd6, 8'b101100}:   cp = 16'h005F;
         {4'd6, 8'b010010}:   cp = 16'h0022;
         {4'd6, 8'b101010}:   cp = 16'h002E;
         {4'd6, 8'b010110}:   cp = 16'h0040;
         {4'd6, 8'b011110}:   cp = 16'h0027;
         {4'd6, 8'b100001}:   cp = 16'h002D;
         {4'd6, 8'b010101}:   cp = 16'h003B;
         {4'd6, 8'b110101}:   cp = 16'h0021;
         {4'd5, 8'b01101}:    cp = 16'h0028;
         {4'd6, 8'b101101}:   cp = 16'h0029;
         {4'd6, 8'b110011}:   cp = 16'h002C;
         {4'd6, 8'b000111}:   cp = 16'h003A;
         {4'd7, 8'b1001000}:  cp = 16'h0024;
         {4'd4, 8'b1010}:     cp = 16'h00E4;
         {4'd4, 8'b0111}:     cp = 16'h00D6;
         {4'd4, 8'b1100}:     cp = 16'h00DC;
         default:             cp = CP_REPLACE;
      endcase
      return cp;
   endfunction

endpackage

[design/mpd_channels.sv]
`timescale 1ns / 1ps
interface mpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pattern_byte;
   logic       end_of_text;

   modport source (output valid, output pattern_byte, output end_of_text, input ready);
   modport sink   (input valid, input pattern_byte, input end_of_text, output ready);
endinterface

interface mpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_point;
   logic        last_of_run;

   modport source (output valid, output code_point, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

[design/mpd_letter_step.sv]
`timescale 1ns / 1ps
module mpd_letter_step #(
   parameter int MAX_SYMBOLS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               pattern_byte,
   input  logic                     end_of_text,
   output mpd_pkg::result_pair_type pair
);

   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SYMBOLS);

   logic [MAX_SYMBOLS-1:0] symbols_ff, symbols_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   invalid_ff, invalid_in;
   logic                   after_space_ff, after_space_in;
   logic                   slash_pending_ff, slash_pending_in;

   logic [MAX_SYMBOLS-1:0] sym;
   logic [CNT_W-1:0]       cnt;
   logic                   inv;
   logic                   was_space;
   logic                   slash_next;
   logic                   space_next;
   logic                   word_break;
   logic                   letter_end;
   logic                   first_ok;
   logic [15:0]            letter_cp;

   always_comb begin
      sym        = symbols_ff;
      cnt        = count_ff;
      inv        = invalid_ff;
      was_space  = after_space_ff;
      slash_next = 1'b0;
      space_next = 1'b0;
      word_break = 1'b0;
      letter_end = 1'b0;
      if (slash_pending_ff && pattern_byte == mpd_pkg::CH_SPACE) begin
         word_break = 1'b1;
      end else begin
         // space, slash and then something else: the slash spoils the new letter
         if (slash_pending_ff) begin
            inv       = 1'b1;
            was_space = 1'b0;
         end
         case (pattern_byte) inside
            mpd_pkg::CH_DOT, mpd_pkg::CH_DASH: begin
               if (cnt >= MAX_CNT) begin
                  inv = 1'b1;
               end else begin
                  if (pattern_byte == mpd_pkg::CH_DASH) begin
                     sym = sym | (MAX_SYMBOLS'(1) << cnt);
                  end
                  cnt = cnt + CNT_W'(1);
               end
            end
            mpd_pkg::CH_SPACE: begin
               letter_end = 1'b1;
               space_next = 1'b1;
            end
            mpd_pkg::CH_SLASH: begin
               if (was_space) begin
                  slash_next = 1'b1;
               end else begin
                  inv = 1'b1;
               end
            end
            default: inv = 1'b1;
         endcase
      end
   end

   // an unfinished word break at end of text also spoils the letter
   always_comb begin
      if (inv || slash_next) begin
         letter_cp = mpd_pkg::CP_REPLACE;
      end else begin
         letter_cp = mpd_pkg::letter_lookup(4'(cnt), 8'(sym));
      end
   end

   // once a word goes out the letter is empty, so a trailing end of text gives 0xfffd
   always_comb begin
      first_ok               = word_break | letter_end;
      pair.num               = 2'(first_ok) + 2'(end_of_text);
      pair.slot0.code_point  = word_break ? mpd_pkg::CP_SPACE : letter_cp;
      pair.slot0.last_of_run = !(first_ok && end_of_text);
      pair.slot1.code_point  = mpd_pkg::CP_REPLACE;
      pair.slot1.last_of_run = 1'b1;
   end

   always_comb begin
      if (word_break || letter_end || end_of_text) begin
         symbols_in = '0;
         count_in   = '0;
         invalid_in = 1'b0;
      end else begin
         symbols_in = sym;
         count_in   = cnt;
         invalid_in = inv;
      end
      after_space_in   = space_next & ~end_of_text;
      slash_pending_in = slash_next & ~end_of_text;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_ff       <= '0;
         count_ff         <= '0;
         invalid_ff       <= 1'b0;
         after_space_ff   <= 1'b0;
         slash_pending_ff <= 1'b0;
      end else if (accept) begin
         symbols_ff       <= symbols_in;
         count_ff         <= count_in;
         invalid_ff       <= invalid_in;
         after_space_ff   <= after_space_in;
         slash_pending_ff <= slash_pending_in;
      end
   end

endmodule

[design/mpd_result_queue.sv]
`timescale 1ns / 1ps
module mpd_result_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mpd_pkg::result_pair_type pair,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mpd_pkg::result_type      out_word
);

   mpd_pkg::result_type entries_ff [mpd_pkg::QUEUE_DEPTH];

   logic [mpd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mpd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mpd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [1:0]                 num_push;
   logic                       pop;

   // room for the worst case of two words from one byte
   assign room      = count_ff <= mpd_pkg::QCNT_W'(mpd_pkg::QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_word  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   assign num_push  = push ? pair.num : 2'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mpd_pkg::QPTR_W'(num_push);
      rd_ptr_in = rd_ptr_ff + mpd_pkg::QPTR_W'(pop);
      count_in  = count_ff + mpd_pkg::QCNT_W'(num_push) - mpd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (num_push != 2'd0) begin
         entries_ff[wr_ptr_ff] <= pair.slot0;
      end
      if (num_push == 2'd2) begin
         entries_ff[wr_ptr_ff + mpd_pkg::QPTR_W'(1)] <= pair.slot1;
      end
   end

endmodule

[design/morse_pattern_decoder_top.sv]
`timescale 1ns / 1ps
// a word is registered in the result queue when the byte that causes it is accepted, and rsp shows the queue head
// throughput: one byte per cycle while req ready is high; a byte that ends a letter together with end of text
// gives two words, which leave one at a time through the single rsp port
// req ready drops while the four-entry result queue holds more than two words
// reset (synchronous, active high) clears the pending letter and empties the queue
module morse_pattern_decoder_top #(
   parameter int MAX_SYMBOLS = 7
) (
   input  logic   clock,
   input  logic   reset,
   mpd_req_if.sink   req_ch,
   mpd_rsp_if.source rsp_ch
);

   mpd_pkg::result_pair_type pair;
   mpd_pkg::result_type      out_word;
   logic                     room;
   logic                     accept;

   assign req_ch.ready = room;
   assign accept       = req_ch.valid & room;

   mpd_letter_step #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pattern_byte (req_ch.pattern_byte),
      .end_of_text  (req_ch.end_of_text),
      .pair         (pair)
   );

   mpd_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .pair      (pair),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_word  (out_word)
   );

   assign rsp_ch.code_point  = out_word.code_point;
   assign rsp_ch.last_of_run = out_word.last_of_run;

endmodule

[design/mpd_checker.sv]
`timescale 1ns / 1ps
module mpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_point,
   input logic        rsp_last_of_run
);

   // after reset the queue is empty and takes bytes at once
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_code_point) && $stable(rsp_last_of_run)))
      else $error("rsp word changed while stalled");

   // every table entry and the word break fit in one byte; only the replacement does not
   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_code_point != 16'hFFFD) |-> (rsp_code_point[15:8] == 8'h00))
      else $error("code point outside the table");

endmodule

bind morse_pattern_decoder_top mpd_checker u_mpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_code_point  (rsp_ch.code_point),
   .rsp_last_of_run (rsp_ch.last_of_run)
);

[verif/morse_pattern_decoder_top_test.sv]
`timescale 1ns / 1ps
module morse_pattern_decoder_top_test;

   localparam int MAX_SYMS = 7;

   class morse_decode_scoreboard #(int MAX_SYM = 7);
      string       letter_pats[57];
      logic [15:0] letter_cps[57];

      logic [7:0] symbols;
      int         count;
      bit         invalid;
      bit         after_sp;
      bit         slash_pend;

      mpd_pkg::result_type expected_words[$];
      int                  failures;

      function new();
         letter_pats = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
            ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
            "..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--",
            "....-", ".....", "-....", "--...", "---..", "----.", "-----", ".-.-.",
            "-...-", "-..-.", ".-...", "..--..", "..--.-", ".-..-.", ".-.-.-", ".--.-.",
            ".----.", "-....-", "-.-.-.", "-.-.--", "-.--.", "-.--.-", "--..--", "---...",
            "...-..-", ".-.-", "---.", "..--"};
         letter_cps = '{16'h41, 16'h42, 16'h43, 16'h44, 16'h45, 16'h46, 16'h47, 16'h48,
            16'h49, 16'h4A, 16'h4B, 16'h4C, 16'h4D, 16'h4E, 16'h4F, 16'h50, 16'h51,
            16'h52, 16'h53, 16'h54, 16'h55, 16'h56, 16'h57, 16'h58, 16'h59, 16'h5A,
            16'h31, 16'h32, 16'h33, 16'h34, 16'h35, 16'h36, 16'h37, 16'h38, 16'h39,
            16'h30, 16'h2B, 16'h3D, 16'h2F, 16'h26, 16'h3F, 16'h5F, 16'h22, 16'h2E,
            16'h40, 16'h27, 16'h2D, 16'h3B, 16'h21, 16'h28, 16'h29, 16'h2C, 16'h3A,
            16'h24, 16'hE4, 16'hD6, 16'hDC};
         symbols    = '0;
         count      = 0;
         invalid    = 1'b0;
         after_sp   = 1'b0;
         slash_pend = 1'b0;
         failures   = 0;
      endfunction

      function void clear_letter();
         symbols = '0;
         count   = 0;
         invalid = 1'b0;
      endfunction

      function logic [15:0] decode_letter();
         string p;
         bit    same;
         if (invalid || count == 0) return mpd_pkg::CP_REPLACE;
         for (int k = 0; k < 57; k++) begin
            p = letter_pats[k];
            if (p.len() == count) begin
               same = 1'b1;
               for (int i = 0; i < count; i++)
                  if ((p[i] == mpd_pkg::CH_DASH) != symbols[i]) same = 1'b0;
               if (same) return letter_cps[k];
            end
         end
         return mpd_pkg::CP_REPLACE;
      endfunction

      function void add_symbol(bit dash);
         if (count >= MAX_SYM) begin
            invalid = 1'b1;
         end else begin
            if (dash) symbols[count] = 1'b1;
            count++;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic eot);
         logic [15:0] run[$];
         bit          was_sp;
         bit          broke_off;
         was_sp    = after_sp;
         after_sp  = 1'b0;
         broke_off = 1'b0;
         if (slash_pend) begin
            slash_pend = 1'b0;
            if (b == mpd_pkg::CH_SPACE) begin
               run.insert(run.size(), mpd_pkg::CP_SPACE);
               clear_letter();
               broke_off = 1'b1;
            end else begin
               // space, slash, then something else: the slash spoils the new letter
               invalid = 1'b1;
               was_sp  = 1'b0;
            end
         end
         if (!broke_off) begin
            if (b == mpd_pkg::CH_DOT) begin
               add_symbol(1'b0);
            end else if (b == mpd_pkg::CH_DASH) begin
               add_symbol(1'b1);
            end else if (b == mpd_pkg::CH_SPACE) begin
               run.insert(run.size(), decode_letter());
               clear_letter();
               after_sp = 1'b1;
            end else if (b == mpd_pkg::CH_SLASH && was_sp) begin
               slash_pend = 1'b1;
            end else begin
               invalid = 1'b1;
            end
         end
         if (eot) begin
            if (slash_pend) invalid = 1'b1;
            run.insert(run.size(), decode_letter());
            clear_letter();
            after_sp   = 1'b0;
            slash_pend = 1'b0;
         end
         foreach (run[i])
            expected_words.insert(expected_words.size(),
                                  mpd_pkg::result_type'{code_point: run[i],
                                                        last_of_run: (i == run.size() - 1)});
      endfunction

      function void report_failure(string msg);
         failures++;
         if (failures <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_word(logic [15:0] cp, logic last_of_run);
         mpd_pkg::result_type exp_word;
         if (expected_words.size() == 0) begin
            report_failure($sformatf("unexpected word code_point %h last_of_run %b",
                                     cp, last_of_run));
            return;
         end
         exp_word = expected_words.pop_front();
         if (cp !== exp_word.code_point)
            report_failure($sformatf("code_point expected %h actual %h",
                                     exp_word.code_point, cp));
         if (last_of_run !== exp_word.last_of_run)
            report_failure($sformatf("last_of_run expected %b actual %b (code_point %h)",
                                     exp_word.last_of_run, last_of_run, cp));
      endfunction

      function void check_drained();
         if (expected_words.size() != 0)
            report_failure($sformatf("%0d words never arrived", expected_words.size()));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic rsp_hold = 1'b0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   items_sent = 0;

   morse_decode_scoreboard #(MAX_SYMS) sb;

   mpd_req_if req_ch ();
   mpd_rsp_if rsp_ch ();

   morse_pattern_decoder_top #(.MAX_SYMBOLS(MAX_SYMS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.pattern_byte <= b;
      req_ch.end_of_text  <= eot;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(b, eot);
      items_sent++;
   endtask

   task automatic send_text(input string s, input bit eot_on_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], eot_on_last && (i == s.len() - 1));
   endtask

   function automatic string random_symbols(int len);
      string s;
      s = "";
      repeat (len) begin
         if ($urandom_range(1)) s = {s, "-"};
         else s = {s, "."};
      end
      return s;
   endfunction

   // mostly well-formed letters and word breaks, some noise and broken breaks
   task automatic run_random(input int n);
      int    first;
      int    pick;
      string body;
      logic [7:0] junk;
      first = items_sent;
      while (items_sent - first < n) begin
         pick = $urandom_range(99);
         body = "";
         if (pick < 55) begin
            body = sb.letter_pats[$urandom_range(56)];
         end else if (pick < 75) begin
            body = random_symbols($urandom_range(1, 8));
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
         end
         send_text(body, 1'b0);
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_text(" ", 1'b0);
         end else if (pick < 78) begin
            send_text(" / ", 1'b0);
         end else if (pick < 85) begin
            do junk = 8'($urandom_range(255)); while (junk == mpd_pkg::CH_SPACE);
            send_text(" /", 1'b0);
            send_byte(junk, 1'b0);
         end else if (pick < 90) begin
            send_byte(mpd_pkg::CH_DASH, 1'b1);
         end else if (pick < 95) begin
            send_text(" ", 1'b1);
         end else begin
            send_text(" / ", 1'b1);
         end
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_word(rsp_ch.code_point, rsp_ch.last_of_run);
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int waited;
      sb = new();
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.pattern_byte <= '0;
      req_ch.end_of_text  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 65;
      // leading space, a letter, two spaces, word break, stray slash
      send_text(" .-  / / /", 1'b0);
      // broken word break into a bad byte, then end of text
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // letter end and end of text on one byte: two words
      send_text("-....- ", 1'b1);
      send_text("..--.-", 1'b1);
      run_random(200);

      // long receiver stall while the sender keeps pushing
      send_idle_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (150) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      run_random(60);

      send_idle_pct = 65;
      recv_idle_pct = 22;
      run_random(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(150);
      req_ch.valid <= 1'b0;

      waited = 0;
      while (sb.expected_words.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      sb.check_drained();
      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
